// File: sv/cht_pkg.sv
// package: table sizing, request and result codes, sequencer states
package cht_pkg;
  localparam int Capacity = 64;
  localparam int SlotW = $clog2(Capacity);
  localparam int LinkW = SlotW + 1;
  localparam int CountW = SlotW + 1;
  localparam logic [LinkW-1:0] NilLink = LinkW'(Capacity);

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_GET    = 2'd1,
    KIND_PUT    = 2'd2,
    KIND_RSVD   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_ABSENT   = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_WRD,     // read entry at walk pointer
    S_WCMP,    // compare key, follow link
    S_SCAN,    // free slot search, one slot a cycle
    S_ORD,     // read occupant of main slot
    S_OCHK,    // decide move or append
    S_PRD,     // read predecessor while relinking
    S_PCHK,
    S_MOVE,    // copy occupant into free slot
    S_FILL,    // write new entry
    S_TAIL,    // link tail to new slot
    S_PUTW,    // overwrite value on hit
    S_RESP
  } state_t;

  typedef struct packed {
    logic [SlotW-1:0] addr;
    logic             we;
    logic [63:0]      key;
    logic [63:0]      val;
    logic [LinkW-1:0] link;
  } mem_req_t;
endpackage

// File: sv/cht_if.sv
// interfaces: request and result channels
interface cht_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] key;
  logic [63:0] value;
  modport source (output valid, kind, key, value, input ready);
  modport sink (input valid, kind, key, value, output ready);
endinterface

interface cht_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  slot;
  logic [63:0] data;
  modport source (output valid, status, slot, data, input ready);
  modport sink (input valid, status, slot, data, output ready);
endinterface

// File: sv/cht_ram.sv
// generic single port ram with registered read
module cht_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // read before write, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: sv/cht_store.sv
// entry store: key, value and link memories sharing one address
module cht_store
  import cht_pkg::*;
(
  input  logic             clk,
  input  mem_req_t         req,
  output logic [63:0]      rd_key,
  output logic [63:0]      rd_val,
  output logic [LinkW-1:0] rd_link
);
  cht_ram #(.Width(64), .Depth(Capacity)) u_keys (
    .clk(clk), .we(req.we), .addr(req.addr), .wdata(req.key), .rdata(rd_key));
  cht_ram #(.Width(64), .Depth(Capacity)) u_vals (
    .clk(clk), .we(req.we), .addr(req.addr), .wdata(req.val), .rdata(rd_val));
  cht_ram #(.Width(LinkW), .Depth(Capacity)) u_links (
    .clk(clk), .we(req.we), .addr(req.addr), .wdata(req.link), .rdata(rd_link));
endmodule

// File: sv/coalesced_hash_table.sv
// request to result: each chain entry walked is read and then compared; an empty main
//   slot skips the read, and a put hit then writes the new value over the entry
// inserts past the walk: scan for a free slot from slot 0, read the main slot,
//   then fill and link the tail, or read the predecessors, copy and fill on a move
// one request at a time; in_ready returns in the cycle after the result is taken
// reset clears the used bits and the entry count at once; no clearing pass
module coalesced_hash_table
  import cht_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  cht_req_if.sink   in_req,
  cht_rsp_if.source out_rsp
);
  state_t state_r, state_nxt;
  logic [Capacity-1:0] used_r, used_nxt;
  logic [CountW-1:0] cnt_r, cnt_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [63:0] key_r, key_nxt, val_r, val_nxt;
  logic [LinkW-1:0] ptr_r, ptr_nxt, tail_r, tail_nxt, fr_r, fr_nxt;
  logic [SlotW:0] steps_r, steps_nxt;
  logic [63:0] okey_r, okey_nxt, oval_r, oval_nxt;
  logic [LinkW-1:0] olink_r, olink_nxt;
  logic [1:0]  st_r, st_nxt;
  logic [SlotW-1:0] slot_r, slot_nxt;
  logic [63:0] data_r, data_nxt;
  mem_req_t mreq;
  logic [63:0] rd_key, rd_val;
  logic [LinkW-1:0] rd_link, nxt_link;
  logic [SlotW-1:0] mp;

  assign mp  = key_r[SlotW-1:0];
  assign nxt_link = (rd_link < NilLink) ? rd_link : NilLink;

  cht_store u_store (.clk(clk), .req(mreq), .rd_key(rd_key), .rd_val(rd_val),
    .rd_link(rd_link));

  // handshake outputs
  assign in_req.ready   = (state_r == S_IDLE);
  assign out_rsp.valid  = (state_r == S_RESP);
  assign out_rsp.status = st_r;
  assign out_rsp.slot   = slot_r;
  assign out_rsp.data   = data_r;

  // next state and datapath
  always_comb begin
    state_nxt = state_r; used_nxt = used_r; cnt_nxt = cnt_r;
    kind_nxt = kind_r; key_nxt = key_r; val_nxt = val_r;
    ptr_nxt = ptr_r; tail_nxt = tail_r; fr_nxt = fr_r; steps_nxt = steps_r;
    okey_nxt = okey_r; oval_nxt = oval_r; olink_nxt = olink_r;
    st_nxt = st_r; slot_nxt = slot_r; data_nxt = data_r;
    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          kind_nxt = in_req.kind; key_nxt = in_req.key;
          val_nxt = (in_req.kind == KIND_PUT) ? in_req.value : 64'd0;
          ptr_nxt = {1'b0, in_req.key[SlotW-1:0]};
          tail_nxt = NilLink; steps_nxt = '0;
          state_nxt = used_r[in_req.key[SlotW-1:0]] ? S_WRD : S_WCMP;
          if (!used_r[in_req.key[SlotW-1:0]]) ptr_nxt = NilLink;
        end
      end
      S_WRD: state_nxt = S_WCMP;
      S_WCMP: begin
        if (ptr_r != NilLink && rd_key == key_r) begin
          st_nxt = ST_FOUND; slot_nxt = ptr_r[SlotW-1:0];
          data_nxt = (kind_r == KIND_PUT) ? val_r : rd_val;
          state_nxt = (kind_r == KIND_PUT) ? S_PUTW : S_RESP;
        end else if (ptr_r != NilLink && steps_r + 1'b1 < (SlotW+1)'(Capacity)
                     && nxt_link != NilLink) begin
          tail_nxt = ptr_r; ptr_nxt = nxt_link; steps_nxt = steps_r + 1'b1;
          state_nxt = S_WRD;
        end else begin
          if (ptr_r != NilLink) tail_nxt = ptr_r;
          if (kind_r == KIND_LOOKUP || kind_r == KIND_RSVD) begin
            st_nxt = ST_ABSENT; slot_nxt = '0; data_nxt = '0; state_nxt = S_RESP;
          end else if (!used_r[mp]) begin
            fr_nxt = {1'b0, mp}; state_nxt = S_FILL;
          end else if (cnt_r >= CountW'(Capacity)) begin
            st_nxt = ST_FULL; slot_nxt = '0; data_nxt = '0; state_nxt = S_RESP;
          end else begin
            fr_nxt = '0; state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!used_r[fr_r[SlotW-1:0]]) begin
          ptr_nxt = {1'b0, mp}; state_nxt = S_ORD;
        end else if (fr_r == LinkW'(Capacity - 1)) begin
          st_nxt = ST_FULL; slot_nxt = '0; data_nxt = '0; state_nxt = S_RESP;
        end else begin
          fr_nxt = fr_r + 1'b1;
        end
      end
      S_ORD: state_nxt = S_OCHK;
      // foreign occupant is captured for the move; an append keeps the tail entry
      S_OCHK: begin
        if (rd_key[SlotW-1:0] != mp) begin
          okey_nxt = rd_key; oval_nxt = rd_val; olink_nxt = nxt_link;
          ptr_nxt = {1'b0, rd_key[SlotW-1:0]}; steps_nxt = '0; state_nxt = S_PRD;
        end else begin
          state_nxt = S_FILL;
        end
      end
      S_PRD: state_nxt = S_PCHK;
      S_PCHK: begin
        if (nxt_link == {1'b0, mp}) begin
          state_nxt = S_MOVE;
        end else if (nxt_link == NilLink || steps_r + 1'b1 >= (SlotW+1)'(Capacity)) begin
          ptr_nxt = NilLink; state_nxt = S_MOVE;
        end else begin
          ptr_nxt = nxt_link; steps_nxt = steps_r + 1'b1; state_nxt = S_PRD;
        end
      end
      S_MOVE: begin
        used_nxt[fr_r[SlotW-1:0]] = 1'b1; state_nxt = S_FILL;
        fr_nxt = {1'b0, mp}; tail_nxt = NilLink;
      end
      S_FILL: begin
        used_nxt[fr_r[SlotW-1:0]] = 1'b1; cnt_nxt = cnt_r + 1'b1;
        st_nxt = ST_INSERTED; slot_nxt = fr_r[SlotW-1:0]; data_nxt = val_r;
        state_nxt = (tail_r != NilLink && fr_r != {1'b0, mp}) ? S_TAIL : S_RESP;
        if (fr_r == {1'b0, mp}) state_nxt = S_RESP;
      end
      S_TAIL: state_nxt = S_RESP;
      S_PUTW: state_nxt = S_RESP;
      S_RESP: if (out_rsp.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory port requests
  always_comb begin
    mreq = '0;
    mreq.key = key_r; mreq.val = val_r; mreq.link = NilLink;
    case (state_r)
      S_WRD, S_PRD: mreq.addr = ptr_r[SlotW-1:0];
      S_ORD:  mreq.addr = mp;
      S_PCHK: begin
        mreq.addr = ptr_r[SlotW-1:0];
        mreq.key = rd_key; mreq.val = rd_val; mreq.link = fr_r;
        mreq.we = (nxt_link == {1'b0, mp});
      end
      S_MOVE: begin
        mreq.addr = fr_r[SlotW-1:0]; mreq.we = 1'b1;
        mreq.key = okey_r; mreq.val = oval_r; mreq.link = olink_r;
      end
      S_FILL: begin
        mreq.addr = fr_r[SlotW-1:0]; mreq.we = 1'b1;
      end
      S_TAIL: begin
        mreq.addr = tail_r[SlotW-1:0]; mreq.we = 1'b1;
        mreq.key = okey_r; mreq.val = oval_r; mreq.link = {1'b0, slot_r};
      end
      S_PUTW: begin
        mreq.addr = slot_r; mreq.we = 1'b1;
        mreq.key = key_r; mreq.val = val_r; mreq.link = olink_r;
      end
      default: mreq.addr = ptr_r[SlotW-1:0];
    endcase
  end

  // last entry compared by the walk is kept for the hit or tail rewrite
  always_ff @(posedge clk) begin
    if (state_r == S_WCMP) begin
      okey_r <= rd_key; oval_r <= rd_val; olink_r <= nxt_link;
    end else begin
      okey_r <= okey_nxt; oval_r <= oval_nxt; olink_r <= olink_nxt;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; used_r <= '0; cnt_r <= '0;
    end else begin
      state_r <= state_nxt; used_r <= used_nxt; cnt_r <= cnt_nxt;
    end
    kind_r <= kind_nxt; key_r <= key_nxt; val_r <= val_nxt;
    ptr_r <= ptr_nxt; tail_r <= tail_nxt; fr_r <= fr_nxt; steps_r <= steps_nxt;
    st_r <= st_nxt; slot_r <= slot_nxt; data_r <= data_nxt;
  end
endmodule

// File: sv/cht_checker.sv
// port-level checker for the hash table, bound to the top level
module cht_checker
  import cht_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic [5:0] out_slot,
  input logic [63:0] out_data
);
  // no new request while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  // a request is never answered in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");
  // absent and full results carry zero slot and data
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_ABSENT || out_status == ST_FULL))
      |-> (out_slot == '0 && out_data == '0)) else $error("nonzero miss");
  // taken result frees the block
  a_ret: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> in_ready) else $error("no return to idle");
endmodule

bind coalesced_hash_table cht_checker u_cht_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_req.valid), .in_ready(in_req.ready),
  .out_valid(out_rsp.valid), .out_ready(out_rsp.ready),
  .out_status(out_rsp.status), .out_slot(out_rsp.slot), .out_data(out_rsp.data));
